>>> hw/rtl/rtps_pkg.sv
// rtps_pkg: shared types and constants of the ready task priority scheduler
// holds command codes, field widths and the beat types that the cell row passes along
// no dependencies
package rtps_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam int MODE_W      = 2;
    localparam int PRIO_W      = 4;
    localparam int IDENT_W     = 8;
    localparam int SEL_IDX_W   = 3;
    localparam int COUNT_OUT_W = 4;

    localparam logic [PRIO_W-1:0] CEILING_RESET = 4'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_START  = 2'd2,
        MODE_SCHED  = 2'd3
    } mode_t;

    // command held steady while the scan wave walks the cell row
    typedef struct packed {
        mode_t                mode;
        logic [PRIO_W-1:0]    prio;
        logic [IDENT_W-1:0]   ident;
    } cmd_t;

    // scan wave handed from cell to cell
    typedef struct packed {
        logic                 active;
        logic [PRIO_W-1:0]    best;
        logic                 found;
    } wave_t;

endpackage

>>> hw/rtl/rtps_if.sv
// rtps_in_if / rtps_out_if: valid-ready channels of the task scheduler
// payload widths come from rtps_pkg
interface rtps_in_if
    import rtps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [PRIO_W-1:0]    priority_req;
    logic [IDENT_W-1:0]   task_id;

    modport source (output valid, output mode, output priority_req, output task_id,
                    input ready);
    modport sink   (input valid, input mode, input priority_req, input task_id,
                    output ready);
endinterface

interface rtps_out_if
    import rtps_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [SEL_IDX_W-1:0]     selected_index;
    logic [PRIO_W-1:0]        selected_priority;
    logic                     found;
    logic [COUNT_OUT_W-1:0]   task_count;
    logic                     status;

    modport source (output valid, output selected_index, output selected_priority,
                    output found, output task_count, output status, input ready);
    modport sink   (input valid, input selected_index, input selected_priority,
                    input found, input task_count, input status, output ready);
endinterface

>>> hw/rtl/ready_task_priority_scheduler_core.sv
// Fixed-priority task scheduler over a table of MAX_TASKS entries, one entry per cell in a row.
// Each command (create, wait current, start by id, schedule) is one input beat and gives one
// result beat. A scan wave enters the first cell in the cycle after the beat is taken and moves
// one cell per clock; each cell applies the command to its own entry and, for wait and
// schedule, keeps the best ready priority not above priority_ceiling (later index wins ties).
// An item goes from the launch register through the cell registers in row order to the SWEEP
// and PUBLISH states; the input stays closed meanwhile and reopens at the edge that loads the
// result, so the next beat can be taken while that result still waits for the sink.
// The user must write priority_ceiling through cfg_wr_en / cfg_wr_data while no command is in
// flight; the block itself does not enforce this.
module ready_task_priority_scheduler_core
    import rtps_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PRIO_W-1:0]   cfg_wr_data,
    rtps_in_if.sink             in_ch,
    rtps_out_if.source          out_ch
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    cmd_t               cmd;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   current;
    wave_t              wave_chain [MAX_TASKS+1];
    logic [IDX_W-1:0]   idx_chain  [MAX_TASKS+1];

    rtps_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cmd         (cmd),
        .count       (count),
        .current     (current),
        .wave_launch (wave_chain[0]),
        .idx_launch  (idx_chain[0]),
        .wave_exit   (wave_chain[MAX_TASKS]),
        .idx_exit    (idx_chain[MAX_TASKS])
    );

    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        rtps_cell #(
            .MAX_TASKS (MAX_TASKS),
            .CELL_IDX  (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .count    (count),
            .current  (current),
            .wave_in  (wave_chain[k]),
            .idx_in   (idx_chain[k]),
            .wave_out (wave_chain[k+1]),
            .idx_out  (idx_chain[k+1])
        );
    end

endmodule

>>> hw/rtl/rtps_cell.sv
// rtps_cell: one table entry of the task scheduler (priority, identifier, ready mark)
// applies the current command as the scan wave passes and hands the wave on
// depends on rtps_pkg
module rtps_cell
    import rtps_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cmd_t                              cmd,
    input  logic [$clog2(MAX_TASKS+1)-1:0]    count,
    input  logic [$clog2(MAX_TASKS)-1:0]      current,
    input  wave_t                             wave_in,
    input  logic [$clog2(MAX_TASKS)-1:0]      idx_in,
    output wave_t                             wave_out,
    output logic [$clog2(MAX_TASKS)-1:0]      idx_out
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [PRIO_W-1:0]  prio_reg;
    logic [IDENT_W-1:0] ident_reg;
    logic               ready_reg;
    logic               ready_next;
    logic               entry_we;
    logic               used;
    wave_t              wave_reg;
    wave_t              wave_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    assign used = (MY_CNT < count);

    always_comb
    begin
        ready_next = ready_reg;
        entry_we   = 1'b0;
        wave_next  = wave_in;
        idx_next   = idx_in;
        if (wave_in.active)
        begin
            case (cmd.mode)
                MODE_CREATE:
                begin
                    if (MY_CNT == count)
                    begin
                        entry_we   = 1'b1;
                        ready_next = 1'b1;
                    end
                end
                MODE_START:
                begin
                    if (used && ident_reg == cmd.ident)
                        ready_next = 1'b1;
                end
                MODE_WAIT:
                begin
                    if (used && MY_IDX == current)
                        ready_next = 1'b0;
                end
                default:
                begin
                end
            endcase
            // later index wins on equal priority
            if ((cmd.mode == MODE_WAIT || cmd.mode == MODE_SCHED) && used && ready_next
                && prio_reg <= wave_in.best)
            begin
                wave_next.best  = prio_reg;
                wave_next.found = 1'b1;
                idx_next        = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            ready_reg <= ready_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (entry_we)
        begin
            prio_reg  <= cmd.prio;
            ident_reg <= cmd.ident;
        end
    end

    assign wave_out = wave_reg;
    assign idx_out  = idx_reg;

endmodule

>>> hw/rtl/rtps_ctrl.sv
// rtps_ctrl: command sequencer of the task scheduler
// takes input beats, launches the scan wave, updates count and selection, drives result beats
// depends on rtps_pkg and rtps_if
module rtps_ctrl
    import rtps_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [PRIO_W-1:0]                 cfg_wr_data,
    rtps_in_if.sink                           in_ch,
    rtps_out_if.source                        out_ch,
    output cmd_t                              cmd,
    output logic [$clog2(MAX_TASKS+1)-1:0]    count,
    output logic [$clog2(MAX_TASKS)-1:0]      current,
    output wave_t                             wave_launch,
    output logic [$clog2(MAX_TASKS)-1:0]      idx_launch,
    input  wave_t                             wave_exit,
    input  logic [$clog2(MAX_TASKS)-1:0]      idx_exit
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TASKS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PUBLISH
    } state_t;

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic                   launch_reg;
    logic [PRIO_W-1:0]      ceiling_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       cur_reg;
    logic                   found_reg;
    logic [PRIO_W-1:0]      sel_prio_reg;
    logic                   status_reg;
    logic                   out_valid_reg;
    logic [SEL_IDX_W-1:0]   out_idx_reg;
    logic [PRIO_W-1:0]      out_prio_reg;
    logic                   out_found_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_status_reg;
    logic                   in_beat;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_beat     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            ceiling_reg   <= CEILING_RESET;
            count_reg     <= '0;
            cur_reg       <= '0;
            found_reg     <= 1'b0;
            sel_prio_reg  <= '0;
            status_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= in_beat;
            if (cfg_wr_en)
                ceiling_reg <= cfg_wr_data;
            // publish reloads the result register itself
            if (out_valid_reg && out_ch.ready && state_reg != ST_PUBLISH)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                        state_reg <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (wave_exit.active)
                    begin
                        status_reg <= (cmd_reg.mode == MODE_CREATE) && (count_reg == CNT_FULL);
                        case (cmd_reg.mode)
                            MODE_CREATE:
                            begin
                                if (count_reg != CNT_FULL)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    // entry priorities never change, so track the selected one here
                                    if (count_reg == CNT_W'(cur_reg))
                                        sel_prio_reg <= cmd_reg.prio;
                                end
                            end
                            MODE_WAIT, MODE_SCHED:
                            begin
                                found_reg <= wave_exit.found;
                                if (wave_exit.found)
                                begin
                                    cur_reg      <= idx_exit;
                                    sel_prio_reg <= wave_exit.best;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        state_reg <= ST_PUBLISH;
                    end
                end
                ST_PUBLISH:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_idx_reg    <= SEL_IDX_W'(cur_reg);
                        out_prio_reg   <= sel_prio_reg;
                        out_found_reg  <= found_reg;
                        out_count_reg  <= COUNT_OUT_W'(count_reg);
                        out_status_reg <= status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg.mode  <= mode_t'(in_ch.mode);
            cmd_reg.prio  <= in_ch.priority_req;
            cmd_reg.ident <= in_ch.task_id;
        end
    end

    assign cmd     = cmd_reg;
    assign count   = count_reg;
    assign current = cur_reg;

    assign wave_launch.active = launch_reg;
    assign wave_launch.best   = ceiling_reg;
    assign wave_launch.found  = 1'b0;
    assign idx_launch         = '0;

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.selected_index    = out_idx_reg;
    assign out_ch.selected_priority = out_prio_reg;
    assign out_ch.found             = out_found_reg;
    assign out_ch.task_count        = out_count_reg;
    assign out_ch.status            = out_status_reg;

endmodule

>>> hw/rtl/rtps_chk.sv
// rtps_chk: port-level checks of the task scheduler, bound to the top level
// depends on rtps_pkg and ready_task_priority_scheduler_core
module rtps_chk
    import rtps_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // one command at a time: input closes after a beat
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after a command beat");

    // a result never shows up the cycle after a command is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared one cycle after a command beat");

    // loading a result reopens the input
    a_result_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input not open when a result was loaded");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped before it was taken");

endmodule

bind ready_task_priority_scheduler_core rtps_chk u_rtps_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
